// ===== rtl/u2u_pkg.sv =====
package u2u_pkg;

  localparam logic [7:0] BYTE_NUL       = 8'h00;
  localparam logic [7:0] BYTE_CONT_LO   = 8'h80;
  localparam logic [7:0] BYTE_LEAD2_LO  = 8'hC0;
  localparam logic [7:0] BYTE_LEAD3_LO  = 8'hE0;
  localparam logic [7:0] BYTE_LEAD4_LO  = 8'hF0;
  localparam logic [7:0] BYTE_BAD_LO    = 8'hF8;

  localparam logic [15:0] HI_SURR_BASE  = 16'hD800;
  localparam logic [15:0] LO_SURR_BASE  = 16'hDC00;
  localparam logic [31:0] SUPP_OFFSET   = 32'h0001_0000;
  localparam logic [15:0] UNITS_MAX     = 16'hFFFF;

  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_ONE  = 2'd1;
  localparam logic [1:0] PEND_TWO  = 2'd2;
  localparam logic [1:0] PEND_THREE = 2'd3;

  // output queue slots, a power of two of at least two
  localparam int OUTQ_DEPTH = 4;

  // decoder state carried between bytes
  typedef struct packed {
    logic [1:0]  pending;
    logic [20:0] acc;
    logic        four;
    logic [15:0] units;
  } u2u_state_t;

  // units produced by one byte, up to two
  typedef struct packed {
    logic [1:0]  n;
    logic [15:0] unit0;
    logic        last0;
    logic [15:0] unit1;
  } u2u_emit_t;

endpackage

// ===== rtl/u2u_decode.sv =====
module u2u_decode
  import u2u_pkg::*;
(
  input  u2u_state_t  st,
  input  logic [7:0]  byte_in,
  input  logic [15:0] max_units,
  output u2u_state_t  st_nxt,
  output u2u_emit_t   emit
);

  logic [20:0] cont;
  logic [20:0] acc_upd;
  logic [1:0]  pend_dec;
  logic [31:0] supp;
  logic [16:0] units_sum;

  // number of units a byte produces, used for the saturating counter
  function automatic logic [1:0] emit_n_f(input u2u_state_t s, input logic [7:0] b,
                                          input logic [15:0] mx);
    logic [1:0] n;
    n = 2'd0;
    if (b == BYTE_NUL) begin
      n = 2'd1;
    end else if (s.pending != PEND_NONE) begin
      if (s.pending == PEND_ONE) begin
        n = s.four ? 2'd2 : 2'd1;
      end
    end else if (s.units < mx && b < BYTE_CONT_LO) begin
      n = 2'd1;
    end
    return n;
  endfunction

  always_comb begin
    cont = {15'd0, byte_in[5:0]};
    case (st.pending)
      PEND_THREE: acc_upd = st.acc | (cont << 12);
      PEND_TWO:   acc_upd = st.acc | (cont << 6);
      PEND_ONE:   acc_upd = st.acc | cont;
      default:    acc_upd = st.acc;
    endcase
    pend_dec  = st.pending - 2'd1;
    supp      = {11'd0, acc_upd} - SUPP_OFFSET;
    units_sum = {1'b0, st.units} + {15'd0, emit_n_f(st, byte_in, max_units)};
  end

  always_comb begin
    st_nxt     = st;
    emit.n     = emit_n_f(st, byte_in, max_units);
    emit.unit0 = 16'd0;
    emit.last0 = 1'b0;
    emit.unit1 = 16'd0;

    if (byte_in == BYTE_NUL) begin
      st_nxt     = '0;
      emit.last0 = 1'b1;
    end else if (st.pending != PEND_NONE) begin
      st_nxt.acc     = acc_upd;
      st_nxt.pending = pend_dec;
      if (pend_dec == PEND_NONE) begin
        if (st.four) begin
          emit.unit0 = HI_SURR_BASE | supp[25:10];
          emit.unit1 = LO_SURR_BASE | {6'd0, supp[9:0]};
        end else begin
          emit.unit0 = acc_upd[15:0];
        end
        st_nxt.acc   = '0;
        st_nxt.four  = 1'b0;
        st_nxt.units = units_sum[16] ? UNITS_MAX : units_sum[15:0];
      end
    end else if (st.units < max_units) begin
      if (byte_in < BYTE_CONT_LO) begin
        emit.unit0   = {8'd0, byte_in};
        st_nxt.units = units_sum[16] ? UNITS_MAX : units_sum[15:0];
      end else if (byte_in < BYTE_LEAD2_LO) begin
        // stray continuation: dropped
      end else if (byte_in < BYTE_LEAD3_LO) begin
        st_nxt.acc     = {10'd0, byte_in[4:0], 6'd0};
        st_nxt.four    = 1'b0;
        st_nxt.pending = PEND_ONE;
      end else if (byte_in < BYTE_LEAD4_LO) begin
        st_nxt.acc     = {5'd0, byte_in[3:0], 12'd0};
        st_nxt.four    = 1'b0;
        st_nxt.pending = PEND_TWO;
      end else if (byte_in < BYTE_BAD_LO) begin
        st_nxt.acc     = {byte_in[2:0], 18'd0};
        st_nxt.four    = 1'b1;
        st_nxt.pending = PEND_THREE;
      end
    end
  end

endmodule

// ===== rtl/u2u_outq.sv =====
module u2u_outq
  import u2u_pkg::*;
(
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  input  u2u_emit_t                       emit,
  input  logic                            pop,
  output logic                            head_valid,
  output logic [15:0]                     head_unit,
  output logic                            head_last,
  output logic [$clog2(OUTQ_DEPTH+1)-1:0] count
);

  localparam int AW = $clog2(OUTQ_DEPTH);
  localparam int CW = $clog2(OUTQ_DEPTH + 1);

  logic [16:0]   mem_r [OUTQ_DEPTH];
  logic [AW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [1:0]    n_push;
  logic          do_pop;

  assign n_push = push ? emit.n : 2'd0;
  assign do_pop = pop && (cnt_r != '0);

  always_comb begin
    wr_nxt  = wr_r + AW'(n_push);
    rd_nxt  = rd_r + AW'(do_pop);
    cnt_nxt = cnt_r + CW'(n_push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem_r[wr_r] <= {emit.unit0, emit.last0};
    end
    if (n_push == 2'd2) begin
      mem_r[wr_r + AW'(1)] <= {emit.unit1, 1'b0};
    end
  end

  assign head_valid = (cnt_r != '0);
  assign head_unit  = mem_r[rd_r][16:1];
  assign head_last  = mem_r[rd_r][0];
  assign count      = cnt_r;

endmodule

// ===== rtl/utf8_to_utf16_transcoder_unit.sv =====
// utf-8 to utf-16 transcoder: one utf-8 byte enters per word on the in_ channel and
// utf-16 code units leave one per word on the out_ channel. a byte is taken into an input
// register, decoded combinationally against the sequence state (pending count, code
// accumulator, four-byte flag, unit counter), and its zero, one or two units go into a
// small output queue, so a new byte can be taken every cycle while units drain. a byte's
// first unit is shown once it has passed the input register and been written to the queue.
// the sustained rate is one byte per cycle while out_stall is low; input stalls only when
// the queue has fewer than two free slots, which the one-unit-per-cycle drain of the out_
// side sets. a zero byte discards any partial sequence, clears the counter and emits a
// zero unit with out_last high. four-byte sequences leave as a surrogate pair.
// cfg_max_units (reset 255) caps units per string; write it only while the block is idle.
module utf8_to_utf16_transcoder_unit
  import u2u_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_max_units,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_code_unit,
  output logic        out_last
);

  localparam int CW = $clog2(OUTQ_DEPTH + 1);

  logic [15:0] max_units_r;
  logic        s1_valid_r, s1_valid_nxt;
  logic [7:0]  s1_byte_r;
  u2u_state_t  st_r, st_nxt;
  u2u_emit_t   emit;
  logic [CW-1:0] q_count;
  logic        advance;
  logic        in_acc;

  // byte in the input register moves on once the queue can hold two units
  assign advance  = s1_valid_r && (q_count <= CW'(OUTQ_DEPTH - 2));
  assign in_stall = s1_valid_r && !advance;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_units_r <= 16'd255;
      s1_valid_r  <= 1'b0;
      st_r        <= '0;
    end else begin
      if (cfg_we) begin
        max_units_r <= cfg_max_units;
      end
      s1_valid_r <= s1_valid_nxt;
      if (advance) begin
        st_r <= st_nxt;
      end
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_byte;
    end
  end

  u2u_decode u_decode (
    .st        (st_r),
    .byte_in   (s1_byte_r),
    .max_units (max_units_r),
    .st_nxt    (st_nxt),
    .emit      (emit)
  );

  u2u_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (advance),
    .emit       (emit),
    .pop        (!out_stall),
    .head_valid (out_valid),
    .head_unit  (out_code_unit),
    .head_last  (out_last),
    .count      (q_count)
  );

  // terminator word always carries a zero unit
  a_last_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> (out_code_unit == 16'd0))
    else $error("terminator with nonzero unit");

  // input only stalls behind an occupied input register
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("stall with empty input register");

  // a decoded nul leaves the sequence state cleared
  a_nul_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s1_byte_r == BYTE_NUL) |=>
      (st_r.pending == PEND_NONE && st_r.units == 16'd0 && !st_r.four))
    else $error("state not cleared after nul");

  // queue never overfills
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= CW'(OUTQ_DEPTH))
    else $error("output queue overflow");

endmodule
